@@ rtl/mexp_pkg.sv @@
// Shared types and constants for the modular exponentiation unit.
package mexp_pkg;

    localparam int FIELD_W = 32;

    typedef logic [FIELD_W-1:0] field_t;

endpackage

@@ rtl/mexp_if.sv @@
// Request and result channel interfaces for the modular exponentiation unit.
interface mexp_in_if;
    logic            valid;
    logic            ready;
    mexp_pkg::field_t base_value;
    mexp_pkg::field_t exponent_value;

    modport source (output valid, output base_value, output exponent_value, input ready);
    modport sink   (input valid, input base_value, input exponent_value, output ready);
endinterface

interface mexp_out_if;
    logic             valid;
    logic             ready;
    mexp_pkg::field_t power_result;
    logic             modulus_error;

    modport source (output valid, output power_result, output modulus_error, input ready);
    modport sink   (input valid, input power_result, input modulus_error, output ready);
endinterface

@@ rtl/modular_exponentiation_unit.sv @@
// Modular exponentiation unit: base^exponent mod modulus, right-to-left square-and-multiply.
//
//  channel   dir  payload                               handshake
//  operand   in   base_value, exponent_value            valid/ready
//  result    out  power_result, modulus_error           valid/ready
//  modulus   cfg  modulus_wdata                         modulus_we, no wait
//
// One request at a time; ready is high only while the sequencer is idle.
// Each request first reduces the base, then runs its modular multiplications;
// W = OPERAND_WIDTH; up to 2W-1 multiplications per request.
// A zero exponent or zero modulus skips the arithmetic and goes straight to the final state.
// All arithmetic runs through one shared double-add / reduce step unit.
// The finished result sits in an output register; a stalled result holds the
// sequencer in its final state. Async active-low reset clears control and modulus.
module modular_exponentiation_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             modulus_we,
    input  mexp_pkg::field_t modulus_wdata,
    mexp_in_if.sink          operand,
    mexp_out_if.source       result
);

    localparam int W     = OPERAND_WIDTH;
    localparam int FW    = mexp_pkg::FIELD_W;
    localparam int CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_SQR    = 3'd3;
    localparam logic [2:0] ST_FIN    = 3'd4;

    logic [2:0]       state_reg, state_next;
    mexp_pkg::field_t modulus_reg;
    logic             out_valid_reg, out_valid_next;
    mexp_pkg::field_t out_power_reg, out_power_next;
    logic             out_err_reg, out_err_next;

    logic [W-1:0]     acc_reg, acc_next;
    logic [W-1:0]     mplier_reg, mplier_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     exp_reg, exp_next;
    logic [W-1:0]     res_reg, res_next;
    logic [W-1:0]     power_reg, power_next;
    logic             err_reg, err_next;

    // field to datapath width: zero-extend or truncate
    logic [W+FW-1:0] base_ext, exp_ext, mod_ext, res_ext;
    logic [W-1:0]    base_w, exp_w, m_w;

    assign base_ext = {{W{1'b0}}, operand.base_value};
    assign exp_ext  = {{W{1'b0}}, operand.exponent_value};
    assign mod_ext  = {{W{1'b0}}, modulus_reg};
    assign res_ext  = {{FW{1'b0}}, res_reg};
    assign base_w   = base_ext[W-1:0];
    assign exp_w    = exp_ext[W-1:0];
    assign m_w      = mod_ext[W-1:0];

    // shared step unit: (2*acc + addend) mod m, with acc < m and addend <= m
    logic [W-1:0] addend;
    logic [W+1:0] step_sum, m1, m2, diff1, diff2;
    logic [W-1:0] unit_out;

    assign addend   = mplier_reg[W-1] ? ((state_reg == ST_REDUCE) ? W'(1) : power_reg)
                                      : '0;
    assign step_sum = {1'b0, acc_reg, 1'b0} + {2'b00, addend};
    assign m1       = {2'b00, m_w};
    assign m2       = {1'b0, m_w, 1'b0};
    assign diff1    = step_sum - m1;
    assign diff2    = step_sum - m2;

    always_comb
    begin
        if (step_sum >= m2)
        begin
            unit_out = diff2[W-1:0];
        end
        else if (step_sum >= m1)
        begin
            unit_out = diff1[W-1:0];
        end
        else
        begin
            unit_out = step_sum[W-1:0];
        end
    end

    assign operand.ready        = (state_reg == ST_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.power_result  = out_power_reg;
    assign result.modulus_error = out_err_reg;

    logic out_free;
    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        mplier_next    = mplier_reg;
        cnt_next       = cnt_reg;
        exp_next       = exp_reg;
        res_next       = res_reg;
        power_next     = power_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        out_power_next = out_power_reg;
        out_err_next   = out_err_reg;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (operand.valid)
                begin
                    exp_next = exp_w;
                    err_next = 1'b0;
                    acc_next = '0;
                    cnt_next = CNT_LAST;
                    if (exp_w == '0)
                    begin
                        res_next   = W'(1);
                        state_next = ST_FIN;
                    end
                    else if (m_w == '0)
                    begin
                        res_next   = '0;
                        err_next   = 1'b1;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        res_next    = (m_w == W'(1)) ? '0 : W'(1);
                        mplier_next = base_w;
                        state_next  = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                acc_next    = unit_out;
                mplier_next = mplier_reg << 1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    power_next = unit_out;
                    acc_next   = '0;
                    cnt_next   = CNT_LAST;
                    if (exp_reg[0])
                    begin
                        state_next  = ST_MUL;
                        mplier_next = res_reg;
                    end
                    else
                    begin
                        state_next  = ST_SQR;
                        mplier_next = unit_out;
                    end
                end
            end
            ST_MUL:
            begin
                acc_next    = unit_out;
                mplier_next = mplier_reg << 1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    res_next = unit_out;
                    acc_next = '0;
                    cnt_next = CNT_LAST;
                    // no higher exponent bits left: later squarings are dead
                    if (exp_reg[W-1:1] == '0)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next  = ST_SQR;
                        mplier_next = power_reg;
                    end
                end
            end
            ST_SQR:
            begin
                acc_next    = unit_out;
                mplier_next = mplier_reg << 1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    power_next = unit_out;
                    exp_next   = exp_reg >> 1;
                    acc_next   = '0;
                    cnt_next   = CNT_LAST;
                    if (exp_reg[1])
                    begin
                        state_next  = ST_MUL;
                        mplier_next = res_reg;
                    end
                    else
                    begin
                        state_next  = ST_SQR;
                        mplier_next = unit_out;
                    end
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_power_next = res_ext[FW-1:0];
                    out_err_next   = err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            modulus_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (modulus_we)
            begin
                modulus_reg <= modulus_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        mplier_reg    <= mplier_next;
        cnt_reg       <= cnt_next;
        exp_reg       <= exp_next;
        res_reg       <= res_next;
        power_reg     <= power_next;
        err_reg       <= err_next;
        out_power_reg <= out_power_next;
        out_err_reg   <= out_err_next;
    end

    // partial product stays reduced while the step unit runs
    a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REDUCE || state_reg == ST_MUL || state_reg == ST_SQR)
        |-> (acc_reg < m_w))
        else $error("accumulator not reduced below modulus");

    a_power_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_SQR) |-> (power_reg < m_w))
        else $error("power not reduced below modulus");

    a_zero_exp_short: assert property (@(posedge clk) disable iff (!rst_n)
        (operand.valid && operand.ready && exp_w == '0) |=> (state_reg == ST_FIN))
        else $error("zero exponent did not finish at once");

    a_error_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.modulus_error) |-> (result.power_result == '0))
        else $error("modulus error with nonzero result");

endmodule
